>>> rtl/hdr_pq_gain_yuv420_block_assert.svh
// ----------------------------------------------------------------------------
// hdr pq gain assertion macros
// shorthand for clocked implication checks, reset-qualified on arst_n
// ----------------------------------------------------------------------------
`ifndef HDR_PQ_GAIN_YUV420_BLOCK_ASSERT_SVH
`define HDR_PQ_GAIN_YUV420_BLOCK_ASSERT_SVH

// same-cycle implication
`define HPG_ASSERT_NOW(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// next-cycle implication
`define HPG_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

>>> rtl/hpg_pkg.sv
// ----------------------------------------------------------------------------
// hpg_pkg
// types and fixed-point constants of the hdr pq gain block
// ----------------------------------------------------------------------------
package hpg_pkg;

	typedef struct packed {
		logic        func;
		logic [9:0]  luma0;
		logic [9:0]  luma1;
		logic [9:0]  luma2;
		logic [9:0]  luma3;
		logic [9:0]  chroma_b;
		logic [9:0]  chroma_r;
		logic [9:0]  table_addr;
		logic [15:0] table_word;
	} in_t;

	typedef struct packed {
		logic [9:0] luma0_out;
		logic [9:0] luma1_out;
		logic [9:0] luma2_out;
		logic [9:0] luma3_out;
		logic [9:0] chroma_b_out;
		logic [9:0] chroma_r_out;
	} out_t;

	localparam logic FUNC_PIXEL = 1'b0;
	localparam logic FUNC_WRITE = 1'b1;

	localparam int GAIN_W = 16;

	// decoder, q14
	localparam longint OFS_LUMA   = 1051659;
	localparam longint OFS_CHROMA = 8413281;
	localparam longint C_Y    = 19076;
	localparam longint C_CR_R = 27612;
	localparam longint C_CB_G = 3082;
	localparam longint C_CR_G = 10697;
	localparam longint C_CB_B = 35227;
	localparam longint HALF_Q28 = 64'sd1 <<< 27;

	// offsets folded with the rounding half
	localparam longint K_R = C_Y * OFS_LUMA + C_CR_R * OFS_CHROMA - HALF_Q28;
	localparam longint K_G = C_Y * OFS_LUMA - C_CB_G * OFS_CHROMA
		- C_CR_G * OFS_CHROMA - HALF_Q28;
	localparam longint K_B = C_Y * OFS_LUMA + C_CB_B * OFS_CHROMA - HALF_Q28;

	// encoder, q14
	localparam int E_Y_R  = 3696;
	localparam int E_Y_G  = 9540;
	localparam int E_Y_B  = 834;
	localparam int E_CB_R = 2002;
	localparam int E_CB_G = 5167;
	localparam int E_CB_B = 7168;
	localparam int E_CR_R = 7168;
	localparam int E_CR_G = 6591;
	localparam int E_CR_B = 577;
	localparam longint CHROMA_BIAS = 64'sd1 <<< 29;

endpackage

>>> rtl/hdr_pq_gain_yuv420_block.sv
// ----------------------------------------------------------------------------
// hdr_pq_gain_yuv420_block
// bt.2020 ycbcr 4:2:0 to rgb, pq gain table lookup, back to ycbcr
// ----------------------------------------------------------------------------
// Takes one 2x2 block of 4:2:0 video per clock and registers its result after
// the stage-1, table-read and stage-3 registers, sustaining one block per cycle
// while the output side does not stall. The pipeline runs: decoder products,
// index forming and table read, encoder products, scaling and clamping. Each
// of the twelve lookups per block has its own copy of the gain table (twelve
// RAM instances); a table-write item writes all copies at the same pipeline
// point where reads happen, so it is ordered with the pixel items around it
// and takes one slot. Table contents are undefined until written; there is no
// clearing pass.
module hdr_pq_gain_yuv420_block #(
	parameter int LUT_DEPTH  = 1024,
	parameter int SAMPLE_MAX = 1023
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         pix_valid,
	output logic         pix_stall,
	input  hpg_pkg::in_t pix,
	output logic         res_valid,
	input  logic         res_stall,
	output hpg_pkg::out_t res
);
	import hpg_pkg::*;

	localparam int AW = $clog2(LUT_DEPTH);
	localparam int IDX_MAX = (SAMPLE_MAX < LUT_DEPTH - 1) ? SAMPLE_MAX : LUT_DEPTH - 1;

	logic en;
	assign en        = !(res_valid && res_stall);
	assign pix_stall = res_valid && res_stall;

	// stage 1: decoder products
	logic        v_s1, func_s1;
	logic [9:0]  taddr_s1;
	logic [15:0] tword_s1;
	logic [24:0] ys_s1 [4];
	logic [25:0] cr_r_s1, cb_g_s1, cr_g_s1, cb_b_s1;
	logic [9:0]  luma_in [4];

	assign luma_in[0] = pix.luma0;
	assign luma_in[1] = pix.luma1;
	assign luma_in[2] = pix.luma2;
	assign luma_in[3] = pix.luma3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= pix_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			func_s1  <= pix.func;
			taddr_s1 <= pix.table_addr;
			tword_s1 <= pix.table_word;
			for (int k = 0; k < 4; k++) begin
				ys_s1[k] <= 25'(luma_in[k] * 15'(C_Y));
			end
			cr_r_s1 <= 26'(pix.chroma_r * 16'(C_CR_R));
			cb_g_s1 <= 26'(pix.chroma_b * 16'(C_CB_G));
			cr_g_s1 <= 26'(pix.chroma_r * 16'(C_CR_G));
			cb_b_s1 <= 26'(pix.chroma_b * 16'(C_CB_B));
		end
	end

	// index forming, q28 round to nearest and clamp
	logic [AW-1:0] idx [4][3];

	always_comb begin
		logic signed [47:0] ch [3];
		logic signed [47:0] ysx;
		for (int k = 0; k < 4; k++) begin
			ysx   = signed'(48'(ys_s1[k]));
			ch[0] = ((ysx + signed'(48'(cr_r_s1))) <<< 14) - 48'(K_R);
			ch[1] = ((ysx - signed'(48'(cb_g_s1)) - signed'(48'(cr_g_s1))) <<< 14)
				- 48'(K_G);
			ch[2] = ((ysx + signed'(48'(cb_b_s1))) <<< 14) - 48'(K_B);
			for (int c = 0; c < 3; c++) begin
				if (ch[c] < 0) begin
					idx[k][c] = '0;
				end else if ((ch[c] >>> 28) > 48'(IDX_MAX)) begin
					idx[k][c] = AW'(IDX_MAX);
				end else begin
					idx[k][c] = AW'(ch[c] >>> 28);
				end
			end
		end
	end

	// stage 2: table read
	logic        v_s2, func_s2;
	logic [GAIN_W-1:0] gain_s2 [4][3];
	logic we, re;

	assign we = en && v_s1 && (func_s1 == FUNC_WRITE) && (32'(taddr_s1) < LUT_DEPTH);
	assign re = en && v_s1 && (func_s1 == FUNC_PIXEL);

	for (genvar k = 0; k < 4; k++) begin : g_pix
		for (genvar c = 0; c < 3; c++) begin : g_ch
			hpg_ram #(
				.WIDTH(GAIN_W),
				.DEPTH(LUT_DEPTH)
			) u_lut (
				.clk  (clk),
				.we   (we),
				.waddr(AW'(taddr_s1)),
				.wdata(tword_s1),
				.re   (re),
				.raddr(idx[k][c]),
				.rdata(gain_s2[k][c])
			);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			func_s2 <= func_s1;
		end
	end

	// stage 3: encoder products, q30
	logic               v_s3, func_s3;
	logic [29:0]        y_s3  [4];
	logic signed [31:0] cb_s3 [4];
	logic signed [31:0] cr_s3 [4];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		logic signed [31:0] gr, gg, gb;
		if (en) begin
			func_s3 <= func_s2;
			for (int k = 0; k < 4; k++) begin
				gr = signed'(32'(gain_s2[k][0]));
				gg = signed'(32'(gain_s2[k][1]));
				gb = signed'(32'(gain_s2[k][2]));
				y_s3[k]  <= 30'(gr * E_Y_R + gg * E_Y_G + gb * E_Y_B);
				cb_s3[k] <= 32'(-gr * E_CB_R - gg * E_CB_G + gb * E_CB_B + 32'(CHROMA_BIAS));
				cr_s3[k] <= 32'(gr * E_CR_R - gg * E_CR_G - gb * E_CR_B + 32'(CHROMA_BIAS));
			end
		end
	end

	// stage 4: scale by sample max, floor, clamp
	logic [9:0] luma_o [4];
	logic [9:0] cb_o, cr_o;

	always_comb begin
		logic [43:0]        yp;
		logic signed [34:0] sb, sr;
		logic [47:0]        pb, pr;
		for (int k = 0; k < 4; k++) begin
			yp = 44'(y_s3[k]) * 44'(SAMPLE_MAX);
			luma_o[k] = ((yp >> 30) > 44'(SAMPLE_MAX)) ? 10'(SAMPLE_MAX) : 10'(yp >> 30);
		end
		sb = 35'(cb_s3[0]) + 35'(cb_s3[1]) + 35'(cb_s3[2]) + 35'(cb_s3[3]);
		sr = 35'(cr_s3[0]) + 35'(cr_s3[1]) + 35'(cr_s3[2]) + 35'(cr_s3[3]);
		pb = 48'(unsigned'(sb)) * 48'(SAMPLE_MAX);
		pr = 48'(unsigned'(sr)) * 48'(SAMPLE_MAX);
		if (sb <= 0) begin
			cb_o = '0;
		end else if ((pb >> 32) > 48'(SAMPLE_MAX)) begin
			cb_o = 10'(SAMPLE_MAX);
		end else begin
			cb_o = 10'(pb >> 32);
		end
		if (sr <= 0) begin
			cr_o = '0;
		end else if ((pr >> 32) > 48'(SAMPLE_MAX)) begin
			cr_o = 10'(SAMPLE_MAX);
		end else begin
			cr_o = 10'(pr >> 32);
		end
	end

	// output register, table writes leave a bubble
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid <= 1'b0;
		end else if (en) begin
			res_valid <= v_s3 && (func_s3 == FUNC_PIXEL);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res.luma0_out    <= luma_o[0];
			res.luma1_out    <= luma_o[1];
			res.luma2_out    <= luma_o[2];
			res.luma3_out    <= luma_o[3];
			res.chroma_b_out <= cb_o;
			res.chroma_r_out <= cr_o;
		end
	end

	logic pix_s3, wr_s3;
	assign pix_s3 = v_s3 && (func_s3 == FUNC_PIXEL);
	assign wr_s3  = v_s3 && (func_s3 == FUNC_WRITE);

`include "hdr_pq_gain_yuv420_block_assert.svh"

	`HPG_ASSERT_NEXT(a_pixel_gives_result, en && pix_s3, res_valid, "pixel block lost")
	`HPG_ASSERT_NEXT(a_write_no_result, en && wr_s3, !res_valid, "table write gave a result")
	`HPG_ASSERT_NOW(a_no_read_write_clash, we, !re, "table read and write together")

endmodule

>>> rtl/hpg_ram.sv
// ----------------------------------------------------------------------------
// hpg_ram
// single write port, single registered read port
// ----------------------------------------------------------------------------
module hpg_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
